### design/mfdl_pkg.sv
// Shared widths, register indexes, reset values and fixed-point constants
// for the modulated feedback delay line. No dependencies.
`timescale 1ns / 1ps

package mfdl_pkg;

	// field widths
	localparam int AUDIO_W  = 24;
	localparam int LFO_W    = 16;
	localparam int SR_W     = 18;
	localparam int DT_W     = 26;
	localparam int GAIN_W   = 17;
	localparam int COEF_W   = 16;
	localparam int SM_W     = 26;  // glide time never leaves [0, 2^26)
	localparam int TIME_FRAC = 24; // time is kept in 2^-24 s

	// configuration port
	localparam int CFG_DATA_W = 26;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TIME  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH      = 3'd5;

	localparam logic [SR_W-1:0]   RST_SAMPLE_RATE = 18'd48000;
	localparam logic [DT_W-1:0]   RST_DELAY_TIME  = 26'd4194304;
	localparam logic [GAIN_W-1:0] RST_FEEDBACK    = 17'd0;
	localparam logic [GAIN_W-1:0] RST_WET_MIX     = 17'd32768;
	localparam logic              RST_DELAY_MODE  = 1'b0;
	localparam logic [COEF_W-1:0] RST_SMOOTH      = 16'd131;

	// fixed-point constants
	localparam int Q16_ONE     = 65536;
	localparam int MOD_BASE    = 50332; // 0.003 s
	localparam int MOD_SPAN    = 33554; // 0.002 s
	localparam int FB_MAX_GAIN = 62259; // 0.95 in Q0.16
	localparam int S24_MAX     = 8388607;
	localparam int S24_MIN     = -8388608;

	// shared multiplier operand width (signed)
	localparam int MUL_W = 28;
	localparam int SAT_W = 28;

	localparam int DEF_BUFFER_DEPTH  = 131072;
	localparam int DEF_FRACTION_BITS = 16;

	function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
		logic signed [AUDIO_W-1:0] r;
		if (v > S24_MAX)
			r = AUDIO_W'(S24_MAX);
		else if (v < S24_MIN)
			r = AUDIO_W'(S24_MIN);
		else
			r = AUDIO_W'(v);
		return r;
	endfunction

endpackage

### design/mfdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### design/modulated_feedback_delay_line.sv
// Modulated feedback delay line: one audio sample and LFO value in, one
// mixed sample out. Each item passes from acceptance to the result register
// through a sequencer that runs every product through one
// shared 28x28 multiplier and reads the two interpolation taps one after the
// other from the delay RAM's single read port; a new item is taken in the
// cycle after the result is loaded, so the block takes one item at a time;
// a finished result waits longer only while the previous beat waits to be
// taken. There is no clearing pass: a write-pointer mark and a wrapped flag
// make never-written buffer entries read as zero. Configuration is to be written
// only between items; the block itself does not enforce this.
// Depends on mfdl_pkg and mfdl_ram.
`timescale 1ns / 1ps

module modulated_feedback_delay_line #(
	parameter int BUFFER_DEPTH  = mfdl_pkg::DEF_BUFFER_DEPTH,
	parameter int FRACTION_BITS = mfdl_pkg::DEF_FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [mfdl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfdl_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mfdl_pkg::AUDIO_W-1:0] audio_in,
	input  logic signed [mfdl_pkg::LFO_W-1:0]   lfo_value,
	input  logic                                block_end,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mfdl_pkg::AUDIO_W-1:0] audio_out,
	output logic                                block_end_out
);

	import mfdl_pkg::*;

	localparam int AW    = $clog2(BUFFER_DEPTH);
	localparam int FB    = FRACTION_BITS;
	localparam int PW    = AW + FB;
	localparam int PW1   = PW + 1;
	localparam int SHIFT = TIME_FRAC - FB;
	localparam int SRPW  = SR_W + SM_W;
	localparam int DLW   = SRPW - SHIFT;
	localparam int PRW   = 2 * MUL_W;
	localparam longint SPAN_L  = longint'(BUFFER_DEPTH) << FB;
	localparam longint LIMIT_L = SPAN_L - 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LFO   = 4'd1;
	localparam logic [3:0] ST_GLIDE = 4'd2;
	localparam logic [3:0] ST_SMUP  = 4'd3;
	localparam logic [3:0] ST_DLY   = 4'd4;
	localparam logic [3:0] ST_CLAMP = 4'd5;
	localparam logic [3:0] ST_ADDR  = 4'd6;
	localparam logic [3:0] ST_RD0   = 4'd7;
	localparam logic [3:0] ST_RD1   = 4'd8;
	localparam logic [3:0] ST_RD2   = 4'd9;
	localparam logic [3:0] ST_INTM  = 4'd10;
	localparam logic [3:0] ST_INTP  = 4'd11;
	localparam logic [3:0] ST_MIX   = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	// control and state
	logic [3:0]               state_q;
	logic                     out_valid_q;
	logic [AW-1:0]            wp_q;
	logic                     wrapped_q;
	logic [SM_W-1:0]          sm_q;
	logic signed [AUDIO_W-1:0] fbk_q;

	// configuration registers
	logic [SR_W-1:0]   sr_q;
	logic [DT_W-1:0]   dt_q;
	logic [GAIN_W-1:0] fba_q;
	logic [GAIN_W-1:0] wet_q;
	logic              mode_q;
	logic [COEF_W-1:0] coeff_q;

	// per-item datapath
	logic signed [AUDIO_W-1:0] x_q;
	logic signed [LFO_W-1:0]   lfo_q;
	logic                      bend_q;
	logic [15:0]               gain_q;
	logic [PW-1:0]             delay_q;
	logic [AW-1:0]             i0_q;
	logic [AW-1:0]             i1_q;
	logic [FB-1:0]             frac_q;
	logic signed [AUDIO_W-1:0] wr_q;
	logic signed [42:0]        acc_q;
	logic                      rv_q;
	logic signed [AUDIO_W-1:0] y0_q;
	logic signed [AUDIO_W:0]   dy_q;
	logic signed [AUDIO_W-1:0] rd_q;
	logic signed [PRW-1:0]     prod_q;
	logic signed [AUDIO_W-1:0] audio_out_q;
	logic                      bend_out_q;

	// shared multiplier
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;

	// combinational helpers
	logic [GAIN_W-1:0]        fb_cap;
	logic [GAIN_W-1:0]        wet_cap;
	logic [GAIN_W-1:0]        dry;
	logic [SM_W:0]            tgt;
	logic signed [SM_W:0]     diff;
	logic [SM_W:0]            sm_next;
	logic [DLW-1:0]           dly_full;
	logic [PW-1:0]            wpos;
	logic [PW:0]              rpos_w;
	logic [AW-1:0]            i1_n;
	logic [AW-1:0]            i0_n;
	logic signed [AUDIO_W:0]  fb_term;
	logic signed [AUDIO_W+1:0] wr_sum;
	logic signed [AUDIO_W-1:0] y1;
	logic [AUDIO_W:0]         rd_sum;
	logic signed [42:0]       mix_sum;
	logic [AW-1:0]            raddr;
	logic [AUDIO_W-1:0]       rdata;
	logic                     ram_we;
	logic                     load_out;

	assign fb_cap  = (fba_q > GAIN_W'(Q16_ONE)) ? GAIN_W'(Q16_ONE) : fba_q;
	assign wet_cap = (wet_q > GAIN_W'(Q16_ONE)) ? GAIN_W'(Q16_ONE) : wet_q;
	assign dry     = GAIN_W'(Q16_ONE) - wet_cap;

	// glide target; the modulated one comes from lfo * span in prod_q
	assign tgt  = mode_q ? ((SM_W+1)'(MOD_BASE) + prod_q[15 +: SM_W+1]) : {1'b0, dt_q};
	assign diff = tgt - {1'b0, sm_q};
	assign sm_next = {1'b0, sm_q} + prod_q[16 +: SM_W+1];

	assign dly_full = prod_q[SHIFT +: DLW];

	// read position behind the write pointer, wrapped into the buffer
	assign wpos   = {wp_q, {FB{1'b0}}};
	assign rpos_w = (delay_q > wpos) ? ({1'b0, wpos} + PW1'(SPAN_L) - {1'b0, delay_q})
	                                 : ({1'b0, wpos} - {1'b0, delay_q});
	assign i1_n   = rpos_w[PW-1:FB];
	assign i0_n   = (i1_n == '0) ? AW'(BUFFER_DEPTH - 1) : i1_n - 1'b1;

	assign fb_term = prod_q[16 +: AUDIO_W+1];
	assign wr_sum  = (AUDIO_W+2)'(x_q) + (AUDIO_W+2)'(fb_term);

	// entry never written reads as zero
	assign y1      = rv_q ? $signed(rdata) : '0;
	assign rd_sum  = (AUDIO_W+1)'(y0_q) + prod_q[FB +: AUDIO_W+1];
	assign mix_sum = acc_q + prod_q[42:0];

	assign ram_we   = (state_q == ST_RD2);
	assign raddr    = (state_q == ST_RD1) ? i1_q : i0_q;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LFO: begin
				mul_a = MUL_W'(lfo_q);
				mul_b = MUL_W'(MOD_SPAN);
			end
			ST_GLIDE: begin
				mul_a = MUL_W'(diff);
				mul_b = MUL_W'(coeff_q);
			end
			ST_SMUP: begin
				mul_a = MUL_W'(fb_cap);
				mul_b = MUL_W'(FB_MAX_GAIN);
			end
			ST_DLY: begin
				mul_a = MUL_W'(sm_q);
				mul_b = MUL_W'(sr_q);
			end
			ST_CLAMP: begin
				mul_a = MUL_W'(fbk_q);
				mul_b = MUL_W'(gain_q);
			end
			ST_ADDR: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(dry);
			end
			ST_INTM: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(frac_q);
			end
			// wet product stays in prod_q while the result waits
			ST_MIX, ST_OUT: begin
				mul_a = MUL_W'(rd_q);
				mul_b = MUL_W'(wet_cap);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	mfdl_ram #(
		.WIDTH(AUDIO_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(wr_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// sequencer, configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			sm_q        <= '0;
			fbk_q       <= '0;
			sr_q        <= RST_SAMPLE_RATE;
			dt_q        <= RST_DELAY_TIME;
			fba_q       <= RST_FEEDBACK;
			wet_q       <= RST_WET_MIX;
			mode_q      <= RST_DELAY_MODE;
			coeff_q     <= RST_SMOOTH;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SAMPLE_RATE: sr_q    <= cfg_data[SR_W-1:0];
					REG_DELAY_TIME:  dt_q    <= cfg_data[DT_W-1:0];
					REG_FEEDBACK:    fba_q   <= cfg_data[GAIN_W-1:0];
					REG_WET_MIX:     wet_q   <= cfg_data[GAIN_W-1:0];
					REG_DELAY_MODE:  mode_q  <= cfg_data[0];
					REG_SMOOTH:      coeff_q <= cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_LFO;
				end
				ST_SMUP: begin
					sm_q    <= sm_next[SM_W-1:0];
					state_q <= ST_DLY;
				end
				ST_OUT: begin
					if (load_out) begin
						fbk_q       <= rd_q;
						if (wp_q == AW'(BUFFER_DEPTH - 1)) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LFO, ST_GLIDE, ST_DLY, ST_CLAMP, ST_ADDR, ST_RD0, ST_RD1,
				ST_RD2, ST_INTM, ST_INTP, ST_MIX: begin
					state_q <= state_q + 4'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				x_q    <= audio_in;
				lfo_q  <= lfo_value;
				bend_q <= block_end;
			end
			ST_DLY: gain_q <= prod_q[31:16];
			ST_CLAMP: begin
				delay_q <= (dly_full > DLW'(LIMIT_L)) ? PW'(LIMIT_L) : dly_full[PW-1:0];
			end
			ST_ADDR: begin
				i1_q   <= i1_n;
				i0_q   <= i0_n;
				frac_q <= rpos_w[FB-1:0];
				wr_q   <= sat24(SAT_W'(wr_sum));
			end
			ST_RD0: begin
				acc_q <= prod_q[42:0];
				rv_q  <= wrapped_q || (i0_q < wp_q);
			end
			ST_RD1: begin
				y0_q <= rv_q ? $signed(rdata) : '0;
				rv_q <= wrapped_q || (i1_q < wp_q);
			end
			ST_RD2: dy_q <= (AUDIO_W+1)'(y1) - (AUDIO_W+1)'(y0_q);
			ST_INTP: rd_q <= rd_sum[AUDIO_W-1:0];
			ST_OUT: begin
				if (load_out) begin
					audio_out_q <= sat24(SAT_W'($signed(mix_sum[42:16])));
					bend_out_q  <= bend_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign audio_out     = audio_out_q;
	assign block_end_out = bend_out_q;

endmodule

### design/mfdl_chk.sv
// Port-level checker for the modulated feedback delay line, bound to the
// top level. Depends on mfdl_pkg and modulated_feedback_delay_line.
`timescale 1ns / 1ps

module mfdl_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [mfdl_pkg::AUDIO_W-1:0] audio_out,
	input logic                                block_end_out
);

	import mfdl_pkg::*;

	logic [AUDIO_W:0] out_word;
	assign out_word = {block_end_out, audio_out};

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result beat changed");

	// one item at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// busy only because a beat was taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("busy without an accepted beat");

	// a new result shows up exactly when the block frees up
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result appeared while still busy");

endmodule

bind modulated_feedback_delay_line mfdl_chk u_mfdl_chk (.*);
